// File: design/assert_macros.svh
// Assertion macros used by the oscillator top level.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks an implication on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Checks that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

// File: design/mwpo_pkg.sv
// Shared constants, types and the sine table function of the oscillator.
// Depends on nothing; used by every module of the block.
package mwpo_pkg;

  localparam int MAX_HARMONICS_DEF   = 1024;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int PHASE_W    = 32;
  localparam int STEP_W     = 31;
  localparam int LFO_W      = 16;
  localparam int DEPTH_W    = 16;
  localparam int SEL_W      = 3;
  localparam int LIMIT_W    = 11;
  localparam int SMP_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  // Dividend of one harmonic term: |sine| * 2^14 stays below 2^29.
  localparam int DIV_NUM_W  = 29;

  localparam logic [PHASE_W-1:0] PULSE_EDGE_HI = 32'd429496730;
  localparam logic [PHASE_W-1:0] PULSE_EDGE_LO = 32'd858993460;

  localparam longint Q30_C = 64'sd1073741824;
  localparam longint C1 = 64'sd1686629713;
  localparam longint C3 = -64'sd693598668;
  localparam longint C5 = 64'sd85569306;
  localparam longint C7 = -64'sd5026994;
  localparam longint C9 = 64'sd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM = 2'd0,
    CFG_DEPTH    = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [SEL_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_PULSE    = 3'd4
  } wave_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SEL,
    ST_H_ADDR,
    ST_H_START,
    ST_H_WAIT,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Q30 product truncated toward zero.
  function automatic longint mul30(longint a, longint b);
    return (a * b) / Q30_C;
  endfunction

  // One sine table entry, evaluated at elaboration from a degree-9 polynomial.
  function automatic logic signed [SMP_W-1:0] sine_entry(int k, int tbits);
    longint qb, quad, r, x, x2, y, v;
    qb   = longint'(tbits - 2);
    quad = longint'(k) >> qb;
    r    = longint'(k) & ((64'sd1 << qb) - 64'sd1);
    if ((quad & 64'sd1) != 0) r = (64'sd1 << qb) - r;
    x  = r << (64'sd30 - qb);
    x2 = mul30(x, x);
    y  = C7 + mul30(x2, C9);
    y  = C5 + mul30(x2, y);
    y  = C3 + mul30(x2, y);
    y  = C1 + mul30(x2, y);
    y  = mul30(x, y);
    if (y < 0) y = 0;
    v = (y * 64'sd32767 + (Q30_C / 2)) / Q30_C;
    if (v > 64'sd32767) v = 64'sd32767;
    if (quad >= 2) v = -v;
    return SMP_W'(v);
  endfunction

endpackage

// File: design/mwpo_sine_rom.sv
// Quantized sine table with a registered read port.
// Depends on mwpo_pkg for the entry function.
module mwpo_sine_rom import mwpo_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic [SINE_TABLE_BITS-1:0]    addr,
  output logic signed [SMP_W-1:0]       data
);

  localparam int DEPTH = 2 ** SINE_TABLE_BITS;

  logic signed [SMP_W-1:0] rom [DEPTH];
  logic signed [SMP_W-1:0] data_r;

  // Every entry is a constant worked out at elaboration.
  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    assign rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  // Registered read.
  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

  assign data = data_r;

endmodule

// File: design/mwpo_serial_div.sv
// Bit-serial restoring divider for the harmonic weights, one quotient bit a cycle.
// Depends on mwpo_pkg for the dividend width and the status struct.
module mwpo_serial_div import mwpo_pkg::*; #(
  parameter int DVW = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIV_NUM_W-1:0]  num,
  input  logic [DVW-1:0]        den,
  output logic [DIV_NUM_W-1:0]  quo,
  output unit_stat_t            stat
);

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] nq_r, nq_nxt;
  logic [DVW-1:0]       d_r;
  logic [DVW-1:0]       rem_r, rem_nxt;
  logic [CW-1:0]        cnt_r;
  logic                 done_r;
  logic [DVW:0]         partial;
  logic                 qbit;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    partial = {rem_r, nq_r[DIV_NUM_W-1]};
    qbit    = (partial >= {1'b0, d_r});
    rem_nxt = qbit ? DVW'(partial - {1'b0, d_r}) : partial[DVW-1:0];
    nq_nxt  = {nq_r[DIV_NUM_W-2:0], qbit};
  end

  // Control: the count runs down once per quotient bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(DIV_NUM_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CW'(1);
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      nq_r  <= nq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo       = nq_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

// File: design/mwpo_phase_inc.sv
// Phase increment step * (1 + lfo * depth), formed from partial products over cycles.
// Depends on mwpo_pkg for the field widths.
module mwpo_phase_inc import mwpo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [STEP_W-1:0]        step,
  input  logic signed [LFO_W-1:0]  lfo,
  input  logic [DEPTH_W-1:0]       depth,
  output logic [PHASE_W-1:0]       inc,
  output logic                     valid
);

  logic [2:0]              stage_r;
  logic                    valid_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [LFO_W-1:0] lfo_r;
  logic [DEPTH_W-1:0]      depth_r;
  logic signed [33:0]      f_r;
  logic [47:0]             pl_r;
  logic signed [48:0]      ph_r;
  logic [PHASE_W-1:0]      inc_r;

  logic signed [32:0]      ld;
  logic signed [33:0]      f_nxt;
  logic [63:0]             sum;

  // Factor in Q3.29 and the recombined product.
  always_comb begin
    ld    = lfo_r * $signed({1'b0, depth_r});
    f_nxt = 34'sd536870912 + 34'(ld);
    sum   = {16'b0, pl_r} + (64'(ph_r) << 17);
  end

  // Stage sequence: factor, low partial product, high partial product, sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 3'd0;
      valid_r <= 1'b0;
    end else if (start) begin
      stage_r <= 3'd1;
      valid_r <= 1'b0;
    end else if (stage_r == 3'd4) begin
      stage_r <= 3'd0;
      valid_r <= 1'b1;
    end else if (stage_r != 3'd0) begin
      stage_r <= stage_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r  <= step;
      lfo_r   <= lfo;
      depth_r <= depth;
    end
    case (stage_r)
      3'd1:    f_r   <= f_nxt;
      3'd2:    pl_r  <= step_r * f_r[16:0];
      3'd3:    ph_r  <= $signed({1'b0, step_r}) * $signed(f_r[33:17]);
      3'd4:    inc_r <= sum[60:29];
      default: ;
    endcase
  end

  assign inc   = inc_r;
  assign valid = valid_r;

endmodule

// File: design/multi_waveform_phase_oscillator_top.sv
// Top level of the multi-waveform phase oscillator: sequencer, registers, handshakes.
// Depends on mwpo_pkg, mwpo_sine_rom, mwpo_serial_div, mwpo_phase_inc, assert_macros.svh.
//
// One request carries a phase step and an LFO value and yields one Q1.15 sample taken
// at the phase held before the advance. Sine, triangle and pulse requests are paced
// by the four-stage phase increment unit.
// Saw and square step through their harmonics with one bit-serial divider, one
// summed harmonic term at a time, which sets the pace of a request (up to 1023 terms
// at the default harmonic cap).
// The input is not ready while a request is at work; a finished sample waits in the
// output register while the next request is taken.
`include "assert_macros.svh"

module multi_waveform_phase_oscillator_top import mwpo_pkg::*; #(
  parameter int MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [30:0] phase_step, [46:31] lfo_value, [47] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] sample_out
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int JW = $clog2(MAX_HARMONICS + 2);
  localparam int LW = (JW > LIMIT_W) ? JW : LIMIT_W;
  localparam int AW = DIV_NUM_W + JW + 1;
  localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
  localparam logic signed [AW-1:0] SAT_LO = AW'(-32768);

  state_t state_r, state_nxt;

  logic [SEL_W-1:0]        wave_r;
  logic [DEPTH_W-1:0]      depth_r;
  logic [LIMIT_W-1:0]      limit_r;
  logic [PHASE_W-1:0]      phase_r;
  logic [PHASE_W-1:0]      p_r;
  logic [PHASE_W-1:0]      phj_r;
  logic [JW-1:0]           j_r;
  logic signed [AW-1:0]    acc_r;
  logic                    neg_r;
  logic signed [SMP_W-1:0] smp_r;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_r;

  logic                    in_fire;
  logic                    load_out;
  logic                    div_start;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic signed [SMP_W-1:0] rom_data;
  logic [DIV_NUM_W-1:0]    div_num;
  logic [DIV_NUM_W-1:0]    div_quo;
  unit_stat_t              div_stat;
  logic [PHASE_W-1:0]      inc;
  logic                    inc_valid;

  logic [LW-1:0]           lim;
  logic                    harm_end;
  logic                    additive;
  logic [PHASE_W-1:0]      pstep;
  logic [JW-1:0]           jstep;
  logic [SMP_W-1:0]        mag;
  logic signed [AW-1:0]    q_ext;
  logic signed [AW-1:0]    rounded;
  logic signed [SMP_W-1:0] sat_smp;
  logic signed [SMP_W-1:0] direct_smp;
  logic signed [17:0]      tri_wide;

  mwpo_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  mwpo_serial_div #(.DVW(JW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (j_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  mwpo_phase_inc u_inc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .step  (in_tdata[30:0]),
    .lfo   ($signed(in_tdata[46:31])),
    .depth (depth_r),
    .inc   (inc),
    .valid (inc_valid)
  );

  // Harmonic bookkeeping, term dividend and the directly decoded waveforms.
  always_comb begin
    lim      = (LW'(limit_r) > LW'(MAX_HARMONICS)) ? LW'(MAX_HARMONICS) : LW'(limit_r);
    harm_end = (LW'(j_r) >= lim);
    additive = (wave_r == WAVE_SAW) || (wave_r == WAVE_SQUARE);
    pstep    = (wave_r == WAVE_SQUARE) ? (p_r << 1) : p_r;
    jstep    = (wave_r == WAVE_SQUARE) ? JW'(2) : JW'(1);
    mag      = rom_data[SMP_W-1] ? SMP_W'(-rom_data) : rom_data;
    div_num  = {mag[14:0], 14'b0};
    q_ext    = AW'(div_quo);
    rounded  = (acc_r + AW'(32768)) >>> 16;
    if (rounded > SAT_HI)      sat_smp = SMP_W'(SAT_HI);
    else if (rounded < SAT_LO) sat_smp = SMP_W'(SAT_LO);
    else                       sat_smp = SMP_W'(rounded);
    if (!p_r[31]) tri_wide = $signed({2'b0, p_r[31:16]}) - 18'sd16384;
    else          tri_wide = 18'sd49152 - $signed({2'b0, p_r[31:16]});
    case (wave_r)
      WAVE_TRIANGLE: direct_smp = SMP_W'(tri_wide);
      WAVE_PULSE: begin
        if (p_r < PULSE_EDGE_HI)      direct_smp = 16'sd16384;
        else if (p_r < PULSE_EDGE_LO) direct_smp = -16'sd16384;
        else                          direct_smp = '0;
      end
      default: direct_smp = rom_data;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_LOOK;
      ST_LOOK:    state_nxt = ST_SEL;
      ST_SEL:     state_nxt = additive ? ST_H_ADDR : ST_DONE;
      ST_H_ADDR:  state_nxt = harm_end ? ST_ROUND : ST_H_START;
      ST_H_START: state_nxt = ST_H_WAIT;
      ST_H_WAIT:  if (div_stat.done) state_nxt = ST_H_ADDR;
      ST_ROUND:   state_nxt = ST_DONE;
      ST_DONE:    if (load_out) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r == ST_H_START);
    load_out  = (state_r == ST_DONE) && inc_valid && (!out_valid_r || out_tready);
    rom_addr  = (state_r == ST_LOOK) ? p_r[PHASE_W-1 -: SINE_TABLE_BITS]
                                     : phj_r[PHASE_W-1 -: SINE_TABLE_BITS];
  end

  assign in_fire = in_tvalid && in_tready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wave_r      <= SEL_W'(WAVE_SINE);
      depth_r     <= '0;
      limit_r     <= LIMIT_W'(1);
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_WAVEFORM: wave_r  <= cfg_wdata[SEL_W-1:0];
          CFG_DEPTH:    depth_r <= cfg_wdata[DEPTH_W-1:0];
          CFG_LIMIT:    limit_r <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        phase_r     <= phase_r + inc;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) p_r <= phase_r;
    case (state_r)
      ST_SEL: begin
        smp_r <= direct_smp;
        j_r   <= JW'(1);
        phj_r <= p_r;
        acc_r <= '0;
      end
      ST_H_START: neg_r <= rom_data[SMP_W-1];
      ST_H_WAIT: begin
        if (div_stat.done) begin
          acc_r <= neg_r ? (acc_r - q_ext) : (acc_r + q_ext);
          j_r   <= j_r + jstep;
          phj_r <= phj_r + pstep;
        end
      end
      ST_ROUND: smp_r <= sat_smp;
      default: ;
    endcase
    if (load_out) out_r <= smp_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // The divider only runs while the sequencer waits on it.
  `ASSERT_IMPLY(a_div_owned, clk, rst_n, div_stat.busy, state_r == ST_H_WAIT)
  // A term is only started for a harmonic below the limit.
  `ASSERT_IMPLY(a_term_in_range, clk, rst_n, div_start, LW'(j_r) < lim)
  // The phase moves only when a sample is handed to the output register.
  `ASSERT_IMPLY(a_phase_on_load, clk, rst_n, !$stable(phase_r) && $past(rst_n), $past(load_out))
  // A new request is never taken while the divider still works.
  `ASSERT_ALWAYS(a_idle_consistent, clk, rst_n, !(in_tready && div_stat.busy))

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the multi-waveform phase oscillator.
// Depends on mwpo_pkg and multi_waveform_phase_oscillator_top; predicts every sample
// in SystemVerilog and compares it with the block's output stream.
`timescale 1ns / 1ps

module tb_top;
  import mwpo_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int TBL_BITS    = SINE_TABLE_BITS_DEF;
  localparam int TBL_LEN     = 1 << TBL_BITS;
  localparam int HARM_CAP    = MAX_HARMONICS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Select codes outside the named list fall back to the sine.
  localparam logic [SEL_W-1:0] WAVE_ALIAS_A = 3'd5;
  localparam logic [SEL_W-1:0] WAVE_ALIAS_B = 3'd6;
  localparam logic [SEL_W-1:0] WAVE_ALIAS_C = 3'd7;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint K1 = 64'sd1686629713;
  localparam longint K3 = -64'sd693598668;
  localparam longint K5 = 64'sd85569306;
  localparam longint K7 = -64'sd5026994;
  localparam longint K9 = 64'sd172272;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state and register shadow.
  logic signed [15:0] sine_rom [TBL_LEN];
  logic [31:0]        osc_phase;
  logic [SEL_W-1:0]   shadow_sel;
  logic [15:0]        shadow_depth;
  logic [10:0]        shadow_limit;

  logic [15:0] expected_samples[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  multi_waveform_phase_oscillator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Q30 product, truncated toward zero.
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / ONE_Q30;
  endfunction

  // Builds the quarter-wave symmetric sine table from the odd polynomial.
  function automatic void build_sine_rom();
    int qb;
    longint quad, r, x, x2, y, v;
    qb = TBL_BITS - 2;
    for (int k = 0; k < TBL_LEN; k++) begin
      quad = longint'(k) >> qb;
      r    = longint'(k) & ((64'sd1 << qb) - 1);
      if (quad[0]) r = (64'sd1 << qb) - r;
      x  = r << (30 - qb);
      x2 = q30_mul(x, x);
      y  = K7 + q30_mul(x2, K9);
      y  = K5 + q30_mul(x2, y);
      y  = K3 + q30_mul(x2, y);
      y  = K1 + q30_mul(x2, y);
      y  = q30_mul(x, y);
      if (y < 0) y = 0;
      v = (y * 32767 + ONE_Q30 / 2) / ONE_Q30;
      if (v > 32767) v = 32767;
      if (quad >= 2) v = -v;
      sine_rom[k] = 16'(v);
    end
  endfunction

  function automatic longint sine_lookup(logic [31:0] ph);
    return longint'(sine_rom[ph[31:32-TBL_BITS]]);
  endfunction

  // Sum of harmonics weighted 1/j, rounded to Q15 and saturated.
  function automatic longint harmonic_sum(logic [31:0] ph, int stride);
    int lim;
    longint acc, t, q;
    logic [31:0] hp;
    acc = 0;
    lim = (shadow_limit > HARM_CAP) ? HARM_CAP : int'(shadow_limit);
    for (int j = 1; j < lim; j += stride) begin
      hp = ph * 32'(j);
      acc += (sine_lookup(hp) * 16384) / longint'(j);
    end
    t = acc + 32768;
    if (t >= 0) q = t >>> 16;
    else q = -(((-t) + 65535) >>> 16);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // Sample at the current phase, then advance the phase by step*(1+lfo*depth).
  function automatic logic [15:0] next_sample(logic [30:0] step, logic signed [15:0] lfo);
    longint smp, factor, prod;
    logic [63:0] uprod;
    case (shadow_sel)
      WAVE_TRIANGLE: smp = (osc_phase < 32'h8000_0000) ?
                           longint'(osc_phase >> 16) - 16384 :
                           49152 - longint'(osc_phase >> 16);
      WAVE_SAW:      smp = harmonic_sum(osc_phase, 1);
      WAVE_SQUARE:   smp = harmonic_sum(osc_phase, 2);
      WAVE_PULSE:    smp = (osc_phase < PULSE_EDGE_HI) ? 16384 :
                           (osc_phase < PULSE_EDGE_LO) ? -16384 : 0;
      default:       smp = sine_lookup(osc_phase);
    endcase
    factor = (64'sd1 << 29) + longint'(lfo) * longint'({1'b0, shadow_depth});
    prod = longint'({1'b0, step}) * factor;
    uprod = prod;
    osc_phase = osc_phase + uprod[60:29];
    return 16'(smp);
  endfunction

  // Output side: random stall and comparison with the oldest expected sample.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %h", out_tdata);
      end else begin
        if (out_tdata !== expected_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected %h, got %h", expected_samples[0], out_tdata);
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  // Sends one request, idling first at the current rate; tvalid stays high afterward.
  task automatic send_request(logic [30:0] step, logic [15:0] lfo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, lfo, step};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_samples.push_back(next_sample(step, lfo));
  endtask

  // Waits until every expected sample has come out and the block is idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Register write; the shadow copy keeps only the register width.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WAVEFORM: shadow_sel   = data[2:0];
      CFG_DEPTH:    shadow_depth = data;
      CFG_LIMIT:    shadow_limit = data[10:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] sel, logic [15:0] depth, logic [15:0] limit);
    drain();
    write_reg(CFG_WAVEFORM, sel);
    write_reg(CFG_DEPTH, depth);
    write_reg(CFG_LIMIT, limit);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  // Sine, triangle, pulse and the spare select codes at extreme and ordinary steps.
  task automatic test_plain_waves();
    send_request(31'd0, 16'h0000);
    send_request(31'h7FFF_FFFF, 16'h0000);
    send_request(31'h1234_5678, 16'h0000);
    set_regs(16'(WAVE_TRIANGLE), 16'd0, 16'd1);
    send_request(31'h4000_0000, 16'h0000);
    send_request(31'h7FFF_FFFF, 16'h0000);
    send_request(31'h3000_0000, 16'h0000);
    set_regs(16'(WAVE_PULSE), 16'd0, 16'd1);
    send_request(31'h0F00_0000, 16'h0000);
    send_request(31'h0F00_0000, 16'h0000);
    send_request(31'h0F00_0000, 16'h0000);
    set_regs(16'(WAVE_ALIAS_A), 16'd0, 16'd1);
    send_request(31'h2345_6789, 16'h0000);
    set_regs(16'(WAVE_ALIAS_C), 16'd0, 16'd1);
    send_request(31'h2345_6789, 16'h0000);
    set_regs({13'h1FFF, WAVE_ALIAS_B}, 16'd0, 16'd1);
    send_request(31'h2345_6789, 16'h0000);
  endtask

  // Pitch modulation at full depth, both LFO extremes, including a reversing phase.
  task automatic test_pitch_mod();
    set_regs(16'(WAVE_TRIANGLE), 16'hFFFF, 16'd1);
    send_request(31'h7FFF_FFFF, 16'h8000);
    send_request(31'h7FFF_FFFF, 16'h7FFF);
    send_request(31'h0123_4567, 16'h8000);
    send_request(31'h0123_4567, 16'hFFFF);
  endtask

  // Additive waves: empty sums, the smallest sum, the full and the clamped limits.
  task automatic test_harmonics();
    set_regs(16'(WAVE_SAW), 16'd0, 16'd0);
    send_request(31'h0765_4321, 16'h0000);
    set_regs(16'(WAVE_SQUARE), 16'd0, 16'd1);
    send_request(31'h0765_4321, 16'h0000);
    set_regs(16'(WAVE_SAW), 16'd0, 16'd2);
    send_request(31'h0765_4321, 16'h0000);
    set_regs(16'(WAVE_SAW), 16'd0, 16'd1024);
    send_request(31'h0765_4321, 16'h0000);
    // Writes to the unused index leave the limit alone.
    drain();
    write_reg(CFG_WAVEFORM, 16'(WAVE_SQUARE));
    write_reg(CFG_DEPTH, 16'd0);
    write_reg(CFG_LIMIT, 16'hFFFF);
    write_reg(CFG_SPARE, 16'd3);
    cfg_we <= 1'b0;
    send_request(31'h0765_4321, 16'h0000);
  endtask

  // Random requests over many register settings and idle patterns.
  task automatic test_random();
    logic [15:0] depth, limit;
    logic [30:0] step;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0: depth = 16'd0;
        1: depth = 16'hFFFF;
        default: depth = 16'($urandom);
      endcase
      limit = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2047)) & 16'h003F :
                                             16'($urandom_range(0, 20));
      set_regs(16'($urandom_range(0, 7)), depth, limit);
      set_idle(ph);
      for (int n = 0; n < 45; n++) begin
        step = 31'($urandom);
        if ($urandom_range(0, 2) == 0) step = step >> $urandom_range(1, 30);
        send_request(step, 16'($urandom));
      end
    end
  endtask

  initial begin
    build_sine_rom();
    osc_phase    = '0;
    shadow_sel   = WAVE_SINE;
    shadow_depth = '0;
    shadow_limit = 11'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_waves();
    test_pitch_mod();
    test_harmonics();
    test_random();
    set_idle(0);
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/mwpo_pkg.sv
design/mwpo_sine_rom.sv
design/mwpo_serial_div.sv
design/mwpo_phase_inc.sv
design/multi_waveform_phase_oscillator_top.sv
dv/tb_top.sv
